FILE: design/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
// used by hcbp_table, hcbp_step and huffman_code_bit_packer_unit
// no dependencies
package hcbp_pkg;

	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 32;
	localparam int CODE_LIMIT   = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int SYM_W        = 8;
	localparam int WORD_W       = 32;
	localparam int LEN_W        = 6;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_ENCODE = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	localparam logic RESULT_BYTE  = 1'b0;
	localparam logic RESULT_ERROR = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
	} code_entry_t;

	// packer state seen by the shared step unit
	typedef struct packed {
		logic [6:0]        acc;
		logic [2:0]        cnt;
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  rem;
	} pack_state_t;

	typedef struct packed {
		logic        emit;
		logic [7:0]  out_val;
		logic        last;
		pack_state_t nxt;
	} step_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RUN,
		ST_ERR,
		ST_FLUSH
	} fsm_state_t;

endpackage

FILE: design/hcbp_table.sv
// code table: one code word and length per symbol, registered read
// depends on hcbp_pkg; entries never written read back as length zero
module hcbp_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [hcbp_pkg::IDX_W-1:0] wr_idx,
	input  hcbp_pkg::code_entry_t      wr_entry,
	input  logic                       rd_en,
	input  logic [hcbp_pkg::IDX_W-1:0] rd_idx,
	output hcbp_pkg::code_entry_t      rd_entry
);
	import hcbp_pkg::*;

	logic [WORD_W+LEN_W-1:0] mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] valid_q;
	logic                    rd_valid_q;
	code_entry_t             rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	// an entry never written reads as absent
	always_comb begin
		rd_entry      = rd_data_q;
		rd_entry.len  = rd_valid_q ? rd_data_q.len : '0;
	end

endmodule

FILE: design/hcbp_step.sv
// shared packing step: completes at most one byte per pass and folds
// leftover code bits back into the accumulator; depends on hcbp_pkg
module hcbp_step (
	input  hcbp_pkg::pack_state_t cur,
	output hcbp_pkg::step_res_t   res
);
	import hcbp_pkg::*;

	logic [3:0]        need;
	logic [6:0]        sum;
	logic [LEN_W-1:0]  rem_new;
	logic [WORD_W-1:0] take;
	logic [15:0]       acc_sh;
	logic [7:0]        take_mask;
	logic [7:0]        low_mask;
	logic [15:0]       fold;

	always_comb begin
		need      = 4'd8 - {1'b0, cur.cnt};
		sum       = 7'(cur.rem) + 7'(cur.cnt);
		rem_new   = cur.rem - LEN_W'(need);
		take      = cur.word >> rem_new;
		acc_sh    = 16'(cur.acc) << need;
		take_mask = 8'((9'd1 << need) - 9'd1);
		low_mask  = 8'((9'd1 << rem_new[2:0]) - 9'd1);
		fold      = (16'(cur.acc) << cur.rem[2:0]) |
			16'(cur.word[7:0] & 8'((9'd1 << cur.rem[2:0]) - 9'd1));

		res         = '0;
		res.nxt     = cur;
		if (sum >= 7'd8) begin
			res.emit    = 1'b1;
			res.out_val = acc_sh[7:0] | (take[7:0] & take_mask);
			res.last    = (rem_new < LEN_W'(8));
			if (res.last) begin
				// remaining bits fit below a byte, fold them now
				res.nxt.acc = 7'(cur.word[7:0] & low_mask);
				res.nxt.cnt = rem_new[2:0];
				res.nxt.rem = '0;
			end else begin
				res.nxt.acc = '0;
				res.nxt.cnt = '0;
				res.nxt.rem = rem_new;
			end
		end else begin
			res.nxt.acc = fold[6:0];
			res.nxt.cnt = sum[2:0];
			res.nxt.rem = '0;
		end
	end

endmodule

FILE: design/huffman_code_bit_packer_unit.sv
// huffman code bit packer, top level
// input beat: tuser = request kind (load, encode, flush); tdata = symbol,
// code word and code length. output beat: tdata = packed byte, earliest
// bit in bit 7; tuser = result kind (byte or unknown-symbol error); tlast
// marks the final result of one input beat.
// a load writes the code table in its accept cycle and is ready again next
// cycle. an encode reads the table through the registered read and then
// runs the shared step unit once per cycle, holding a pass while a
// completed byte waits for the output register: each pass completes one
// byte or folds the tail bits. an unknown symbol gives one error beat and
// leaves the packer untouched. a flush with pending bits gives one
// zero-padded byte. s_tready is high only while the sequencer is idle;
// one beat is handled at a time.
// a result waits in the output register while m_tready is low, and the
// sequencer stalls on the next byte until the register frees up.
// reset clears the pending bits, the output valid and every table valid
// bit, so all symbols read as absent until loaded.
// depends on hcbp_pkg, hcbp_table, hcbp_step
module huffman_code_bit_packer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // symbol[7:0], code_bits[39:8], code_len[45:40], zero pad
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic [0:0]  m_tuser,  // result_kind[0]
	output logic        m_tlast
);
	import hcbp_pkg::*;

	fsm_state_t        state_q, state_d;
	pack_state_t       pk_q, pk_d;
	logic              m_tvalid_q;
	logic [7:0]        out_byte_q;
	logic              kind_q;
	logic              last_q;

	logic              accept;
	logic              out_free;
	logic              emit;
	logic [7:0]        emit_byte;
	logic              emit_kind;
	logic              emit_last;

	logic [SYM_W-1:0]  in_sym;
	logic [WORD_W-1:0] in_bits;
	logic [LEN_W-1:0]  in_len;
	logic              sym_ok;
	logic              tbl_wr;
	logic              tbl_rd;
	code_entry_t       wr_entry;
	code_entry_t       rd_entry;
	pack_state_t       step_in;
	step_res_t         step_out;
	logic [15:0]       flush_sh;

	assign in_sym  = s_tdata[7:0];
	assign in_bits = s_tdata[39:8];
	assign in_len  = s_tdata[45:40];
	assign sym_ok  = (9'(in_sym) < 9'(SYMBOL_COUNT));

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign tbl_wr = accept && (s_tuser == REQ_LOAD) && sym_ok;
	assign tbl_rd = accept && (s_tuser == REQ_ENCODE) && sym_ok;

	always_comb begin
		wr_entry.word = in_bits;
		wr_entry.len  = (in_len > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : in_len;
	end

	hcbp_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tbl_wr),
		.wr_idx   (in_sym[IDX_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (tbl_rd),
		.rd_idx   (in_sym[IDX_W-1:0]),
		.rd_entry (rd_entry)
	);

	assign step_in = pk_q;

	hcbp_step u_step (
		.cur (step_in),
		.res (step_out)
	);

	assign flush_sh = 16'(pk_q.acc) << (4'd8 - {1'b0, pk_q.cnt});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pk_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pk_q    <= pk_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			kind_q     <= emit_kind;
			last_q     <= emit_last;
		end
	end

	always_comb begin
		state_d   = state_q;
		pk_d      = pk_q;
		emit      = 1'b0;
		emit_byte = '0;
		emit_kind = RESULT_BYTE;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_tuser)
						REQ_ENCODE: state_d = sym_ok ? ST_LOOKUP : ST_ERR;
						REQ_FLUSH:  state_d = (pk_q.cnt != 3'd0) ? ST_FLUSH : ST_IDLE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				if (rd_entry.len == '0) begin
					state_d = ST_ERR;
				end else begin
					pk_d.word = rd_entry.word;
					pk_d.rem  = rd_entry.len;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				// hold the pass while a completed byte has nowhere to go
				if (!step_out.emit || out_free) begin
					pk_d      = step_out.nxt;
					emit      = step_out.emit;
					emit_byte = step_out.out_val;
					emit_last = step_out.last;
					if (step_out.nxt.rem == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = RESULT_ERROR;
					state_d   = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_byte = flush_sh[7:0];
					pk_d.acc  = '0;
					pk_d.cnt  = '0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = out_byte_q;
	assign m_tuser[0] = kind_q;
	assign m_tlast    = last_q;

endmodule
